// ----- design/mlsp_pkg.sv -----
// Shared types and constants for the markup line span parser.
// Used by the front, queue, back and top-level modules; no dependencies.
package mlsp_pkg;

	localparam int STACK_DEPTH    = 16;
	localparam int MAX_LINE_CHARS = 4096;
	localparam int IDXW           = 13;
	localparam int CAP            = (MAX_LINE_CHARS > 8191) ? 8191 : MAX_LINE_CHARS;
	localparam int STKW           = $clog2(STACK_DEPTH);
	localparam int SPW            = $clog2(STACK_DEPTH + 1);
	localparam int QDEPTH         = 4;
	localparam int QPW            = $clog2(QDEPTH);

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_SPAN = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	localparam logic [1:0] SPAN_BOLD   = 2'd0;
	localparam logic [1:0] SPAN_ITALIC = 2'd1;
	localparam logic [1:0] SPAN_BOTH   = 2'd2;

	localparam logic [1:0] ALIGN_LEFT    = 2'd0;
	localparam logic [1:0] ALIGN_RIGHT   = 2'd1;
	localparam logic [1:0] ALIGN_JUSTIFY = 2'd2;
	localparam logic [1:0] ALIGN_CENTER  = 2'd3;

	localparam logic [1:0] HDR_NONE = 2'd0;
	localparam logic [1:0] HDR_H3   = 2'd1;
	localparam logic [1:0] HDR_H2   = 2'd2;
	localparam logic [1:0] HDR_H1   = 2'd3;

	typedef enum logic [1:0] {OP_TEXT, OP_MARK, OP_SUM} op_code_t;

	// One classified action handed from the front to the back.
	typedef struct packed {
		logic            valid;
		op_code_t        code;
		logic [7:0]      data;
		logic [1:0]      mtype;
		logic [IDXW-1:0] idx;
		logic [1:0]      al;
		logic [1:0]      hd;
		logic [IDXW-1:0] hlen;
	} op_t;

	// Up to two actions per input transfer; op0 is always filled first.
	typedef struct packed {
		op_t op1;
		op_t op0;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0]      mtype;
		logic [IDXW-1:0] idx;
	} stk_t;

endpackage

// ----- design/markup_line_span_parser_top.sv -----
// Top level of the markup line span parser: front, action queue and back.
// Depends on mlsp_pkg, mlsp_front, mlsp_fifo and mlsp_back.
//
// Input channel s_*: one transfer per text byte (s_tuser 0, byte in s_tdata)
// or per end of line (s_tuser 1). Output channel m_*: one transfer per result;
// m_tuser is the kind (text byte, closed span, line summary) and m_tlast marks
// the result of the final action caused by one input transfer.
// The front decodes alignment and header prefixes, UTF-8 continuation and the
// two-byte marker lookahead in the accepting cycle and writes up to two
// actions into a four-entry queue. The back applies each action to the
// open-span stack and the output register, one per cycle unless m_* stalls.
// Each action of an input transfer passes through the queue and the output
// register; the second action of the same transfer follows the first.
// Throughput: one input per cycle while s_tready is high; an input with two
// actions (a marker plus a byte, or a final byte plus the line summary) holds
// the back for both actions, and a marker that only opens a span takes a back
// step without a result. When m_tready stays low the output register holds,
// the queue fills and s_tready drops once four entries wait. Reset empties the
// queue and the output register and starts a new line with an empty span stack.
module markup_line_span_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // text_byte, span_type, span_start, span_end,
	                               // alignment, header_level, header_length,
	                               // stack_overflow, zero fill
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // last
);

	mlsp_pkg::q_stat_t q_stat;
	mlsp_pkg::entry_t  push_entry;
	mlsp_pkg::entry_t  head;
	logic              push;
	logic              pop;

	mlsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	mlsp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	mlsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- design/mlsp_front.sv -----
// Front end: accepts bytes and end-of-line transfers, tracks line prefixes,
// lookahead and UTF-8 continuation, and emits classified actions. Uses mlsp_pkg.
module mlsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tuser,
	input  mlsp_pkg::q_stat_t     q_stat,
	output logic                  push,
	output mlsp_pkg::entry_t      push_entry
);

	typedef enum logic [1:0] {PH_ALIGN, PH_HEADER, PH_SPACE, PH_BODY} phase_t;

	typedef struct packed {
		phase_t                    phase;
		logic [2:0][7:0]           b;
		logic [1:0]                n;
		logic [1:0]                cont;
		logic [mlsp_pkg::IDXW-1:0] ci;
		logic [mlsp_pkg::IDXW-1:0] hc;
		logic [1:0]                al;
		logic [1:0]                hd;
	} ps_t;

	typedef struct packed {
		ps_t            s;
		logic           stop;
		mlsp_pkg::op_t  op;
	} step_t;

	function automatic logic [mlsp_pkg::IDXW-1:0] sat_add(
		logic [mlsp_pkg::IDXW-1:0] v, logic [1:0] k);
		logic [mlsp_pkg::IDXW:0] t;
		t = {1'b0, v} + {{(mlsp_pkg::IDXW-1){1'b0}}, k};
		return (t > (mlsp_pkg::IDXW+1)'(mlsp_pkg::CAP)) ?
			mlsp_pkg::IDXW'(mlsp_pkg::CAP) : t[mlsp_pkg::IDXW-1:0];
	endfunction

	function automatic logic [1:0] lead_extra(logic [7:0] b);
		logic [1:0] r;
		r = 2'd0;
		if (b[7:5] == 3'b110) r = 2'd1;
		else if (b[7:4] == 4'b1110) r = 2'd2;
		else if (b[7:3] == 5'b11110) r = 2'd3;
		return r;
	endfunction

	function automatic ps_t drop(ps_t s, logic [1:0] k);
		ps_t r;
		r = s;
		case (k)
			2'd1: r.b = {8'h00, s.b[2], s.b[1]};
			2'd2: r.b = {8'h00, 8'h00, s.b[2]};
			2'd3: r.b = '0;
			default: r.b = s.b;
		endcase
		r.n = (s.n > k) ? s.n - k : 2'd0;
		return r;
	endfunction

	function automatic step_t take_char(ps_t s);
		step_t r;
		r = '0;
		r.op.valid = 1'b1;
		r.op.code  = mlsp_pkg::OP_TEXT;
		r.op.data  = s.b[0];
		r.s        = s;
		r.s.cont   = lead_extra(s.b[0]);
		r.s.ci     = sat_add(s.ci, 2'd1);
		r.s.hc     = sat_add(s.hc, 2'd1);
		r.s        = drop(r.s, 2'd1);
		return r;
	endfunction

	function automatic step_t take_mark(ps_t s, logic [1:0] len, logic [1:0] mt);
		step_t r;
		r = '0;
		r.op.valid = 1'b1;
		r.op.code  = mlsp_pkg::OP_MARK;
		r.op.mtype = mt;
		r.op.idx   = s.ci;
		r.s        = s;
		r.s.hc     = sat_add(s.hc, len);
		r.s        = drop(r.s, len);
		return r;
	endfunction

	// One decision on the lookahead; stop means wait for more bytes.
	function automatic step_t step(ps_t s, logic eol);
		step_t      r;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		r  = '0;
		r.s = s;
		b0 = s.b[0];
		b1 = s.b[1];
		b2 = s.b[2];
		if (s.n == 2'd0) begin
			r.stop = 1'b1;
		end else begin
			unique case (s.phase)
				PH_ALIGN: begin
					if (s.n < 2'd2) begin
						if (!eol) r.stop = 1'b1;
						else r.s.phase = PH_HEADER;
					end else begin
						r.s.phase = PH_HEADER;
						if (b0 == mlsp_pkg::CH_LT && b1 == mlsp_pkg::CH_MINUS) begin
							r.s.al = mlsp_pkg::ALIGN_LEFT;
							r.s = drop(r.s, 2'd2);
						end else if (b0 == mlsp_pkg::CH_MINUS && b1 == mlsp_pkg::CH_GT) begin
							r.s.al = mlsp_pkg::ALIGN_RIGHT;
							r.s = drop(r.s, 2'd2);
						end else if (b0 == mlsp_pkg::CH_LT && b1 == mlsp_pkg::CH_GT) begin
							r.s.al = mlsp_pkg::ALIGN_JUSTIFY;
							r.s = drop(r.s, 2'd2);
						end else if (b0 == mlsp_pkg::CH_CARET && b1 == mlsp_pkg::CH_CARET) begin
							r.s.al = mlsp_pkg::ALIGN_CENTER;
							r.s = drop(r.s, 2'd2);
						end
					end
				end
				PH_HEADER: begin
					if (b0 != mlsp_pkg::CH_HASH) begin
						r.s.phase = PH_BODY;
					end else if (s.n < 2'd2) begin
						if (!eol) begin
							r.stop = 1'b1;
						end else begin
							r.s.hd = mlsp_pkg::HDR_H1;
							r.s = drop(r.s, 2'd1);
							r.s.phase = PH_SPACE;
						end
					end else if (b1 != mlsp_pkg::CH_HASH) begin
						r.s.hd = mlsp_pkg::HDR_H1;
						r.s = drop(r.s, 2'd1);
						r.s.phase = PH_SPACE;
					end else if (s.n < 2'd3) begin
						if (!eol) begin
							r.stop = 1'b1;
						end else begin
							r.s.hd = mlsp_pkg::HDR_H2;
							r.s = drop(r.s, 2'd2);
							r.s.phase = PH_SPACE;
						end
					end else if (b2 == mlsp_pkg::CH_HASH) begin
						r.s.hd = mlsp_pkg::HDR_H3;
						r.s = drop(r.s, 2'd3);
						r.s.phase = PH_SPACE;
					end else begin
						r.s.hd = mlsp_pkg::HDR_H2;
						r.s = drop(r.s, 2'd2);
						r.s.phase = PH_SPACE;
					end
				end
				PH_SPACE: begin
					if (b0 == mlsp_pkg::CH_SPACE) r.s = drop(r.s, 2'd1);
					r.s.phase = PH_BODY;
				end
				PH_BODY: begin
					if (s.cont != 2'd0) begin
						r.op.valid = 1'b1;
						r.op.code  = mlsp_pkg::OP_TEXT;
						r.op.data  = b0;
						r.s.cont   = s.cont - 2'd1;
						r.s = drop(r.s, 2'd1);
					end else if (b0 == mlsp_pkg::CH_STAR) begin
						if (s.n < 2'd2) begin
							if (!eol) r.stop = 1'b1;
							else r = take_char(s);
						end else if (b1 != mlsp_pkg::CH_STAR) begin
							r = take_char(s);
						end else if (s.n < 2'd3) begin
							if (!eol) r.stop = 1'b1;
							else r = take_mark(s, 2'd2, mlsp_pkg::SPAN_BOLD);
						end else if (b2 == mlsp_pkg::CH_STAR) begin
							r = take_mark(s, 2'd3, mlsp_pkg::SPAN_BOTH);
						end else begin
							r = take_mark(s, 2'd2, mlsp_pkg::SPAN_BOLD);
						end
					end else if (b0 == mlsp_pkg::CH_US) begin
						if (s.n < 2'd2) begin
							if (!eol) r.stop = 1'b1;
							else r = take_char(s);
						end else if (b1 == mlsp_pkg::CH_US) begin
							r = take_mark(s, 2'd2, mlsp_pkg::SPAN_ITALIC);
						end else begin
							r = take_char(s);
						end
					end else begin
						r = take_char(s);
					end
				end
				default: r.stop = 1'b1;
			endcase
		end
		return r;
	endfunction

	ps_t              st_q;
	ps_t              cur;
	ps_t              nxt;
	ps_t              fresh;
	step_t            sr;
	logic             stopped;
	logic             eol;
	mlsp_pkg::op_t    o0;
	mlsp_pkg::op_t    o1;
	mlsp_pkg::op_t    sum;
	logic             acc;

	assign eol      = s_tuser;
	assign s_tready = !q_stat.full;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		fresh       = '0;
		fresh.phase = PH_ALIGN;
		fresh.al    = mlsp_pkg::ALIGN_JUSTIFY;
		cur = st_q;
		if (!eol && st_q.n < 2'd3) begin
			cur.b[st_q.n] = s_tdata;
			cur.n = st_q.n + 2'd1;
		end
		stopped = 1'b0;
		o0 = '0;
		o1 = '0;
		// At most five decisions fit one transfer: prefix, header, space, two body bytes.
		for (int i = 0; i < 5; i++) begin
			sr = step(cur, eol);
			if (!stopped) begin
				if (sr.stop) begin
					stopped = 1'b1;
				end else begin
					cur = sr.s;
					if (sr.op.valid) begin
						if (!o0.valid) o0 = sr.op;
						else o1 = sr.op;
					end
				end
			end
		end
		sum       = '0;
		sum.valid = 1'b1;
		sum.code  = mlsp_pkg::OP_SUM;
		sum.al    = cur.al;
		sum.hd    = cur.hd;
		sum.hlen  = (cur.hd != mlsp_pkg::HDR_NONE) ? cur.hc : '0;
		nxt = cur;
		if (eol) begin
			nxt = fresh;
			if (!o0.valid) o0 = sum;
			else o1 = sum;
		end
		push_entry.op0 = o0;
		push_entry.op1 = o1;
		push = acc && o0.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_ALIGN, b: '0, n: 2'd0, cont: 2'd0, ci: '0, hc: '0,
				al: mlsp_pkg::ALIGN_JUSTIFY, hd: mlsp_pkg::HDR_NONE};
		end else if (acc) begin
			st_q <= nxt;
		end
	end

endmodule

// ----- design/mlsp_fifo.sv -----
// Short queue of classified actions between front and back.
// Uses mlsp_pkg for the entry type and depth.
module mlsp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mlsp_pkg::entry_t  push_entry,
	input  logic              pop,
	output mlsp_pkg::entry_t  head,
	output mlsp_pkg::q_stat_t q_stat
);

	mlsp_pkg::entry_t         mem_q [mlsp_pkg::QDEPTH];
	logic [mlsp_pkg::QPW-1:0] wr_q;
	logic [mlsp_pkg::QPW-1:0] rd_q;
	logic [mlsp_pkg::QPW:0]   cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = (cnt_q == (mlsp_pkg::QPW+1)'(mlsp_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (mlsp_pkg::QPW+1)'(push) - (mlsp_pkg::QPW+1)'(pop);
		end
	end

endmodule

// ----- design/mlsp_back.sv -----
// Back end: runs queued actions against the open-span stack and drives the
// registered result stream. Uses mlsp_pkg.
module mlsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mlsp_pkg::entry_t  head,
	input  mlsp_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	mlsp_pkg::stk_t           stk_q [mlsp_pkg::STACK_DEPTH];
	logic [mlsp_pkg::SPW-1:0] sp_q;
	logic [mlsp_pkg::SPW-1:0] spm1;
	logic                     ovf_q;
	logic                     sel_q;
	logic                     m_valid_q;
	logic [55:0]              data_q;
	logic [1:0]               kind_q;
	logic                     last_q;
	mlsp_pkg::op_t            op;
	mlsp_pkg::stk_t           top;
	logic                     go;
	logic                     hit;
	logic                     lst;
	logic [55:0]              res_word;
	logic [1:0]               res_kind;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	assign op   = sel_q ? head.op1 : head.op0;
	assign go   = !q_stat.empty && (!m_valid_q || m_tready);
	assign spm1 = sp_q - 1'b1;
	assign top  = stk_q[spm1[mlsp_pkg::STKW-1:0]];
	assign hit  = (sp_q != '0) && (top.mtype == op.mtype);
	assign lst  = sel_q || !head.op1.valid;
	assign pop  = go && lst;

	always_comb begin
		res_word = '0;
		res_kind = mlsp_pkg::KIND_TEXT;
		case (op.code)
			mlsp_pkg::OP_TEXT: res_word[7:0] = op.data;
			mlsp_pkg::OP_MARK: begin
				res_kind        = mlsp_pkg::KIND_SPAN;
				res_word[9:8]   = op.mtype;
				res_word[22:10] = top.idx;
				res_word[35:23] = op.idx;
			end
			default: begin
				res_kind        = mlsp_pkg::KIND_LINE;
				res_word[37:36] = op.al;
				res_word[39:38] = op.hd;
				res_word[52:40] = op.hlen;
				res_word[53]    = ovf_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (go && op.code == mlsp_pkg::OP_MARK && !hit &&
		    sp_q < (mlsp_pkg::SPW)'(mlsp_pkg::STACK_DEPTH)) begin
			stk_q[sp_q[mlsp_pkg::STKW-1:0]] <= '{mtype: op.mtype, idx: op.idx};
		end
		if (go) begin
			data_q <= res_word;
			kind_q <= res_kind;
			last_q <= lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			ovf_q     <= 1'b0;
			sel_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// a marker that only opens a span leaves no result
			if (go) m_valid_q <= (op.code != mlsp_pkg::OP_MARK) || hit;
			else if (m_tready) m_valid_q <= 1'b0;
			if (go) begin
				sel_q <= !lst;
				case (op.code)
					mlsp_pkg::OP_TEXT: ;
					mlsp_pkg::OP_MARK: begin
						// close on a matching top, else open, else flag the drop
						if (hit) sp_q <= spm1;
						else if (sp_q < (mlsp_pkg::SPW)'(mlsp_pkg::STACK_DEPTH))
							sp_q <= sp_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					default: begin
						sp_q  <= '0;
						ovf_q <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule

// ----- design/mlsp_checker.sv -----
// Port-level checks for the markup line span parser, bound to the top level.
// Uses mlsp_pkg for the result kind codes.
module mlsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// hold a stalled result transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mlsp_pkg::KIND_SPAN |-> m_tdata[22:10] <= m_tdata[35:23])
		else $error("span closes before it opens");

	a_line_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mlsp_pkg::KIND_LINE |-> m_tlast)
		else $error("line summary not marked last");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == mlsp_pkg::KIND_TEXT |-> m_tdata[55:8] == '0)
		else $error("text result carries span or line fields");

endmodule

bind markup_line_span_parser_top mlsp_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
